/* rtl/core/east_asian_width_lookup_defines.svh */
// ----------------------------------------------------------------------------
// East Asian width lookup: assertion macros
// Concurrent assertion wrappers used by the RTL of the block (eawl_search).
// ----------------------------------------------------------------------------
`ifndef EAST_ASIAN_WIDTH_LOOKUP_DEFINES_SVH
`define EAST_ASIAN_WIDTH_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define EAWL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define EAWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define EAWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define EAWL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/eawl_pkg.sv */
// ----------------------------------------------------------------------------
// eawl_pkg
// Types, codes and the class-to-column map of the East Asian width lookup.
// ----------------------------------------------------------------------------
package eawl_pkg;

    localparam int OP_W    = 2;
    localparam int CP_W    = 21;
    localparam int IDX_W   = 11;
    localparam int CLS_W   = 3;
    localparam int COL_W   = 2;
    localparam int CFG_W   = 12;

    localparam int ASCII_DEPTH = 128;
    localparam int ASCII_AW    = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RANGE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_ASCII = 2'd2;

    // width classes
    localparam logic [CLS_W-1:0] CLS_ERROR = 3'd0;
    localparam logic [CLS_W-1:0] CLS_N     = 3'd1;
    localparam logic [CLS_W-1:0] CLS_A     = 3'd2;
    localparam logic [CLS_W-1:0] CLS_H     = 3'd3;
    localparam logic [CLS_W-1:0] CLS_W_CL  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_F     = 3'd5;
    localparam logic [CLS_W-1:0] CLS_NA    = 3'd6;

    typedef struct packed {
        logic [CP_W-1:0]  range_first;
        logic [CP_W-1:0]  range_last;
        logic [CLS_W-1:0] cls;
    } t_span;

    localparam int SPAN_W = $bits(t_span);

    // table write request from the control unit
    typedef struct packed {
        logic             range_we;
        logic             ascii_we;
        logic [IDX_W-1:0] index;
        t_span            span;
    } t_load;

    // registered read data of all table banks
    typedef struct packed {
        t_span            lo;
        t_span            hi;
        t_span            mid;
        logic [CLS_W-1:0] ascii_cls;
    } t_rd_data;

    function automatic logic [COL_W-1:0] class_columns(input logic [CLS_W-1:0] cls);
        logic [COL_W-1:0] cols;
        case (cls)
            CLS_N:    cols = 2'd1;
            CLS_A:    cols = 2'd2;
            CLS_H:    cols = 2'd1;
            CLS_W_CL: cols = 2'd2;
            CLS_F:    cols = 2'd2;
            CLS_NA:   cols = 2'd1;
            default:  cols = 2'd0;
        endcase
        return cols;
    endfunction

endpackage

/* rtl/core/eawl_if.sv */
// ----------------------------------------------------------------------------
// eawl_if
// Valid/ready channels of the East Asian width lookup: input items and results.
// ----------------------------------------------------------------------------
interface eawl_item_if;
    logic                          valid;
    logic                          ready;
    logic [eawl_pkg::OP_W-1:0]     operation;
    logic [eawl_pkg::CP_W-1:0]     code_point;
    logic [eawl_pkg::IDX_W-1:0]    entry_index;
    logic [eawl_pkg::CP_W-1:0]     range_first;
    logic [eawl_pkg::CP_W-1:0]     range_last;
    logic [eawl_pkg::CLS_W-1:0]    entry_class;

    modport source (
        output valid, operation, code_point, entry_index, range_first, range_last,
               entry_class,
        input  ready
    );
    modport sink (
        input  valid, operation, code_point, entry_index, range_first, range_last,
               entry_class,
        output ready
    );
endinterface

interface eawl_result_if;
    logic                          valid;
    logic                          ready;
    logic [eawl_pkg::CLS_W-1:0]    width_class;
    logic [eawl_pkg::COL_W-1:0]    display_width;

    modport source (
        output valid, width_class, display_width,
        input  ready
    );
    modport sink (
        input  valid, width_class, display_width,
        output ready
    );
endinterface

/* rtl/core/eawl_ram.sv */
// ----------------------------------------------------------------------------
// eawl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eawl_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/eawl_store.sv */
// ----------------------------------------------------------------------------
// eawl_store
// Range table in three read banks (low, high, mid end of the search interval)
// and the ASCII class table; drops loads that fall outside a table.
// ----------------------------------------------------------------------------
module eawl_store #(
    parameter int RANGE_DEPTH = 2048
) (
    input  logic                          i_clk,
    input  eawl_pkg::t_load               i_load,
    input  logic [$clog2(RANGE_DEPTH)-1:0] i_lo_addr,
    input  logic [$clog2(RANGE_DEPTH)-1:0] i_hi_addr,
    input  logic [$clog2(RANGE_DEPTH)-1:0] i_mid_addr,
    input  logic [eawl_pkg::ASCII_AW-1:0] i_ascii_addr,
    output eawl_pkg::t_rd_data            o_rd
);

    localparam int AW = $clog2(RANGE_DEPTH);

    logic                              range_we;
    logic                              ascii_we;
    logic [AW-1:0]                     range_waddr;
    logic [eawl_pkg::SPAN_W-1:0]       rd_lo;
    logic [eawl_pkg::SPAN_W-1:0]       rd_hi;
    logic [eawl_pkg::SPAN_W-1:0]       rd_mid;

    // drop writes beyond either table
    assign range_we = i_load.range_we &&
                      (32'(i_load.index) < 32'(RANGE_DEPTH));
    assign ascii_we = i_load.ascii_we &&
                      (i_load.index[eawl_pkg::IDX_W-1:eawl_pkg::ASCII_AW] == '0);
    assign range_waddr = AW'(i_load.index);

    eawl_ram #(.WIDTH(eawl_pkg::SPAN_W), .DEPTH(RANGE_DEPTH)) u_bank_lo (
        .i_clk   (i_clk),
        .i_we    (range_we),
        .i_waddr (range_waddr),
        .i_wdata (i_load.span),
        .i_raddr (i_lo_addr),
        .o_rdata (rd_lo)
    );

    eawl_ram #(.WIDTH(eawl_pkg::SPAN_W), .DEPTH(RANGE_DEPTH)) u_bank_hi (
        .i_clk   (i_clk),
        .i_we    (range_we),
        .i_waddr (range_waddr),
        .i_wdata (i_load.span),
        .i_raddr (i_hi_addr),
        .o_rdata (rd_hi)
    );

    eawl_ram #(.WIDTH(eawl_pkg::SPAN_W), .DEPTH(RANGE_DEPTH)) u_bank_mid (
        .i_clk   (i_clk),
        .i_we    (range_we),
        .i_waddr (range_waddr),
        .i_wdata (i_load.span),
        .i_raddr (i_mid_addr),
        .o_rdata (rd_mid)
    );

    eawl_ram #(.WIDTH(eawl_pkg::CLS_W), .DEPTH(eawl_pkg::ASCII_DEPTH)) u_ascii (
        .i_clk   (i_clk),
        .i_we    (ascii_we),
        .i_waddr (i_load.index[eawl_pkg::ASCII_AW-1:0]),
        .i_wdata (i_load.span.cls),
        .i_raddr (i_ascii_addr),
        .o_rdata (o_rd.ascii_cls)
    );

    assign o_rd.lo  = eawl_pkg::t_span'(rd_lo);
    assign o_rd.hi  = eawl_pkg::t_span'(rd_hi);
    assign o_rd.mid = eawl_pkg::t_span'(rd_mid);

endmodule

/* rtl/core/eawl_search.sv */
// ----------------------------------------------------------------------------
// eawl_search
// Item handshake, binary search sequencer over the range banks, and the
// result output register.
// ----------------------------------------------------------------------------
`include "east_asian_width_lookup_defines.svh"

module eawl_search #(
    parameter int RANGE_DEPTH = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(RANGE_DEPTH+1)-1:0]   i_count,
    eawl_item_if.sink                          i_item,
    eawl_result_if.source                      o_result,
    output eawl_pkg::t_load                    o_load,
    output logic [$clog2(RANGE_DEPTH)-1:0]     o_lo_addr,
    output logic [$clog2(RANGE_DEPTH)-1:0]     o_hi_addr,
    output logic [$clog2(RANGE_DEPTH)-1:0]     o_mid_addr,
    output logic [eawl_pkg::ASCII_AW-1:0]      o_ascii_addr,
    input  eawl_pkg::t_rd_data                 i_rd
);

    localparam int AW = $clog2(RANGE_DEPTH);
    localparam int CW = $clog2(RANGE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ASCII  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [CW-1:0]                  r_lo, n_lo;
    logic [CW-1:0]                  r_hi, n_hi;
    logic [CW-1:0]                  r_mid, n_mid;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [eawl_pkg::CP_W-1:0]      r_cp, n_cp;
    logic [eawl_pkg::CLS_W-1:0]     r_cls, n_cls;
    logic                           r_out_valid, n_out_valid;
    logic [eawl_pkg::CLS_W-1:0]     r_out_cls;
    logic [eawl_pkg::COL_W-1:0]     r_out_width;

    logic                           accept;
    logic                           is_query;
    logic                           cp_ascii;
    logic                           out_load;
    logic                           lo_hit;
    logic                           hi_hit;
    logic                           out_of_range;
    logic [CW:0]                    mid_sum;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign is_query     = (i_item.operation == eawl_pkg::OP_QUERY);
    assign cp_ascii     = (i_item.code_point[eawl_pkg::CP_W-1:eawl_pkg::ASCII_AW] == '0);

    // table writes go out at the transfer edge
    assign o_load.range_we         = accept && (i_item.operation == eawl_pkg::OP_LOAD_RANGE);
    assign o_load.ascii_we         = accept && (i_item.operation == eawl_pkg::OP_LOAD_ASCII);
    assign o_load.index            = i_item.entry_index;
    assign o_load.span.range_first = i_item.range_first;
    assign o_load.span.range_last  = i_item.range_last;
    assign o_load.span.cls         = i_item.entry_class;

    // read data belongs to the r_lo / r_hi / r_mid addresses of the last edge
    assign lo_hit = (i_rd.lo.range_first <= r_cp) && (r_cp <= i_rd.lo.range_last);
    assign hi_hit = (i_rd.hi.range_first <= r_cp) && (r_cp <= i_rd.hi.range_last);
    assign out_of_range = (r_lo >= r_cnt) || (r_hi >= r_cnt);

    assign out_load = (r_state == S_RESULT) && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_cnt   = r_cnt;
        n_cp    = r_cp;
        n_cls   = r_cls;
        case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    n_cp  = i_item.code_point;
                    n_cnt = i_count;
                    n_lo  = '0;
                    n_hi  = i_count - CW'(1);
                    if (cp_ascii) begin
                        n_state = S_ASCII;
                    end else if (i_count == '0) begin
                        n_cls   = eawl_pkg::CLS_ERROR;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_ASCII: begin
                n_cls   = i_rd.ascii_cls;
                n_state = S_RESULT;
            end
            S_SEARCH: begin
                if (out_of_range) begin
                    n_cls   = eawl_pkg::CLS_ERROR;
                    n_state = S_RESULT;
                end else if (lo_hit) begin
                    n_cls   = i_rd.lo.cls;
                    n_state = S_RESULT;
                end else if (hi_hit) begin
                    n_cls   = i_rd.hi.cls;
                    n_state = S_RESULT;
                end else if (r_hi <= r_lo) begin
                    n_cls   = eawl_pkg::CLS_ERROR;
                    n_state = S_RESULT;
                end else if (r_cp < i_rd.mid.range_first) begin
                    n_lo = r_lo + CW'(1);
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                    n_hi = r_hi - CW'(1);
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // midpoint of the next interval feeds the mid bank address directly
    assign mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid   = mid_sum[CW:1];

    assign o_lo_addr    = n_lo[AW-1:0];
    assign o_hi_addr    = n_hi[AW-1:0];
    assign o_mid_addr   = n_mid[AW-1:0];
    assign o_ascii_addr = i_item.code_point[eawl_pkg::ASCII_AW-1:0];

    assign n_out_valid = out_load || (r_out_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_cnt <= n_cnt;
        r_cp  <= n_cp;
        r_cls <= n_cls;
        if (out_load) begin
            r_out_cls   <= r_cls;
            r_out_width <= eawl_pkg::class_columns(r_cls);
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.width_class   = r_out_cls;
    assign o_result.display_width = r_out_width;

    `EAWL_ASSERT(a_interval_bounds, i_clk, i_rst_n, (r_state == S_SEARCH) |-> ((r_hi < r_cnt) && (r_lo <= r_cnt)), "search interval left the table")
    `EAWL_ASSERT(a_interval_shrinks, i_clk, i_rst_n, ((r_state == S_SEARCH) && ($past(r_state) == S_SEARCH)) |-> ((r_hi < $past(r_hi)) || (r_lo > $past(r_lo))), "search step did not narrow the interval")
    `EAWL_ASSERT(a_load_stays_idle, i_clk, i_rst_n, (i_item.valid && i_item.ready && (i_item.operation != eawl_pkg::OP_QUERY)) |=> (r_state == S_IDLE), "non-query item started a lookup")
    `EAWL_ASSERT(a_width_matches, i_clk, i_rst_n, r_out_valid |-> (r_out_width == eawl_pkg::class_columns(r_out_cls)), "display width disagrees with class")

endmodule

/* rtl/core/east_asian_width_lookup.sv */
// ----------------------------------------------------------------------------
// east_asian_width_lookup
// Classifies a code point into an East Asian width class and column count:
// direct ASCII table below 0x80, binary search over loaded ranges above.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    operation, code_point, entry_index,
//                                 range_first, range_last, entry_class
//  o_result   out  valid/ready    width_class, display_width
//  i_cfg_*    in   write enable   entries_in_use (12 bits)
//
//  Loads may follow one another in back-to-back cycles.
//  An ASCII query passes through the ASCII read state and the result state
//  before the input is free again; a range query runs its search steps (at most
//  about log2(entries_in_use) + 2), one step per cycle through the three range banks.
//  Synchronous active-low reset clears the control state and entries_in_use;
//  the tables are not cleared.
//  A result that is not taken holds in the output register; a finished search
//  then waits and the input stays stalled until the register frees.
// ----------------------------------------------------------------------------
module east_asian_width_lookup #(
    parameter int RANGE_DEPTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eawl_pkg::CFG_W-1:0]     i_cfg_wdata,
    eawl_item_if.sink                      i_item,
    eawl_result_if.source                  o_result
);

    localparam int AW = $clog2(RANGE_DEPTH);
    localparam int CW = $clog2(RANGE_DEPTH + 1);

    // saturated range count, held in search form
    logic [CW-1:0]             r_count, n_count;

    eawl_pkg::t_load           load;
    eawl_pkg::t_rd_data        rd;
    logic [AW-1:0]             lo_addr;
    logic [AW-1:0]             hi_addr;
    logic [AW-1:0]             mid_addr;
    logic [eawl_pkg::ASCII_AW-1:0] ascii_addr;

    // clamp the count to the table depth at write time
    always_comb begin
        n_count = r_count;
        if (i_cfg_we) begin
            if (32'(i_cfg_wdata) > 32'(RANGE_DEPTH)) begin
                n_count = CW'(RANGE_DEPTH);
            end else begin
                n_count = CW'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // sequencer: handshake, search steps, output register
    eawl_search #(.RANGE_DEPTH(RANGE_DEPTH)) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_count      (r_count),
        .i_item       (i_item),
        .o_result     (o_result),
        .o_load       (load),
        .o_lo_addr    (lo_addr),
        .o_hi_addr    (hi_addr),
        .o_mid_addr   (mid_addr),
        .o_ascii_addr (ascii_addr),
        .i_rd         (rd)
    );

    // tables: three read banks of the range table plus the ASCII table
    eawl_store #(.RANGE_DEPTH(RANGE_DEPTH)) u_store (
        .i_clk        (i_clk),
        .i_load       (load),
        .i_lo_addr    (lo_addr),
        .i_hi_addr    (hi_addr),
        .i_mid_addr   (mid_addr),
        .i_ascii_addr (ascii_addr),
        .o_rd         (rd)
    );

endmodule

/* sim/east_asian_width_lookup_tb.sv */
// ----------------------------------------------------------------------------
// east_asian_width_lookup_tb
// Self-checking bench for the East Asian width lookup. It loads the ASCII
// class table and a series of range tables, then queries each of them.
// Tables are sorted and disjoint, or plain noise. The range count is set to
// empty, small, full and oversized values. Every query is predicted by a
// software binary search kept in step with the loads, and each result is
// checked in order.
// ----------------------------------------------------------------------------
module east_asian_width_lookup_tb;
    import eawl_pkg::*;

    localparam int RANGE_DEPTH  = 2048;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 32;

    localparam logic [CP_W-1:0]  ASCII_LIMIT = 21'h80;
    localparam logic [CP_W-1:0]  CP_TOP      = 21'h1FFFFF;
    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic [CLS_W-1:0] CLS_SEVEN   = 3'd7;
    localparam logic [CFG_W-1:0] CFG_TOP     = 12'hFFF;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CP_W-1:0]  cp;
        logic [IDX_W-1:0] idx;
        logic [CP_W-1:0]  first;
        logic [CP_W-1:0]  last;
        logic [CLS_W-1:0] cls;
    } width_req_t;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [COL_W-1:0] cols;
    } width_answer_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    eawl_item_if   item_ch ();
    eawl_result_if result_ch ();

    east_asian_width_lookup #(
        .RANGE_DEPTH (RANGE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // Items waiting for the driver, and answers waiting for the result port.
    width_req_t    pending_reqs[$];
    width_answer_t expected_widths[$];

    // Predictor state: range table, ASCII table and the range count, updated
    // as loads transfer and as the count is written.
    logic [CP_W-1:0]  span_first [RANGE_DEPTH];
    logic [CP_W-1:0]  span_last  [RANGE_DEPTH];
    logic [CLS_W-1:0] span_cls   [RANGE_DEPTH];
    logic [CLS_W-1:0] ascii_cls  [ASCII_DEPTH];
    int unsigned      entries_cfg;

    // Stimulus side copy of the planned ranges, used to aim queries at the
    // edges of loaded entries before those loads have even transferred.
    logic [CP_W-1:0]  aim_first [RANGE_DEPTH];
    logic [CP_W-1:0]  aim_last  [RANGE_DEPTH];

    int unsigned fail_count;
    int unsigned query_count;
    int unsigned high_query_count;
    int unsigned load_count;
    int unsigned setting_count;
    int unsigned random_items;

    // ------------------------------------------------------------------------
    // Clock, and the hard stop for a hung run
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("east_asian_width_lookup test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [COL_W-1:0] columns_of(input logic [CLS_W-1:0] cls);
        case (cls)
            CLS_N, CLS_H, CLS_NA:    return 2'd1;
            CLS_A, CLS_W_CL, CLS_F:  return 2'd2;
            default:                 return 2'd0;
        endcase
    endfunction

    // Binary search with both ends tested first, then the interval narrowed
    // around the midpoint; a count beyond the table depth is clipped.
    function automatic logic [CLS_W-1:0] search_span_table(input logic [CP_W-1:0] cp);
        int unsigned count, lo, hi, mid;
        count = (entries_cfg > RANGE_DEPTH) ? RANGE_DEPTH : entries_cfg;
        if (count == 0) return CLS_ERROR;
        lo = 0;
        hi = count - 1;
        for (int guard = 0; guard <= RANGE_DEPTH; guard++) begin
            if (lo >= count || hi >= count) return CLS_ERROR;
            if (span_first[lo] <= cp && cp <= span_last[lo]) return span_cls[lo];
            if (span_first[hi] <= cp && cp <= span_last[hi]) return span_cls[hi];
            if (hi <= lo) return CLS_ERROR;
            mid = (lo + hi) / 2;
            if (cp < span_first[mid]) begin
                lo = lo + 1;
                hi = mid;
            end else begin
                lo = mid;
                hi = hi - 1;
            end
        end
        return CLS_ERROR;
    endfunction

    function automatic width_answer_t classify_code_point(input logic [CP_W-1:0] cp);
        width_answer_t ans;
        ans.cls  = (cp < ASCII_LIMIT) ? ascii_cls[cp[ASCII_AW-1:0]] : search_span_table(cp);
        ans.cols = columns_of(ans.cls);
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of random length, random gaps in between; hold the
    // payload steady until the transfer happens.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;
    width_req_t  next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                item_ch.operation   <= next_req.op;
                item_ch.code_point  <= next_req.cp;
                item_ch.entry_index <= next_req.idx;
                item_ch.range_first <= next_req.first;
                item_ch.range_last  <= next_req.last;
                item_ch.entry_class <= next_req.cls;
                item_ch.valid       <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready follows a rotating 16-bit pattern that is redrawn
    // every so often; some patterns are all ones, so no stall at all.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;
    int unsigned stall_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_pattern = '1;
            stall_phase   = '0;
            stall_hold    = 0;
        end else begin
            if (stall_hold == 0) begin
                stall_hold = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = ($urandom & $urandom) | 16'h0001;
                    default: stall_pattern = $urandom | 16'h0001;
                endcase
            end else begin
                stall_hold--;
            end
            result_ch.ready <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first (a query that transfers now cannot answer
    // at the same edge), then advance the predictor with the input transfer.
    // ------------------------------------------------------------------------
    width_answer_t want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_widths.size() == 0) begin
                    $error("unexpected result: width_class %0d display_width %0d",
                           result_ch.width_class, result_ch.display_width);
                    fail_count++;
                end else begin
                    want = expected_widths.pop_front();
                    if (result_ch.width_class !== want.cls) begin
                        $error("width_class mismatch: expected %0d, actual %0d",
                               want.cls, result_ch.width_class);
                        fail_count++;
                    end
                    if (result_ch.display_width !== want.cols) begin
                        $error("display_width mismatch: expected %0d, actual %0d",
                               want.cols, result_ch.display_width);
                        fail_count++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                case (item_ch.operation)
                    OP_QUERY: begin
                        expected_widths.push_back(classify_code_point(item_ch.code_point));
                        query_count++;
                        if (item_ch.code_point >= ASCII_LIMIT) high_query_count++;
                    end
                    OP_LOAD_RANGE: begin
                        span_first[item_ch.entry_index] = item_ch.range_first;
                        span_last[item_ch.entry_index]  = item_ch.range_last;
                        span_cls[item_ch.entry_index]   = item_ch.entry_class;
                        load_count++;
                    end
                    OP_LOAD_ASCII: begin
                        // slots past the ASCII block are dropped by the block
                        if (item_ch.entry_index < ASCII_DEPTH) begin
                            ascii_cls[item_ch.entry_index[ASCII_AW-1:0]] = item_ch.entry_class;
                            load_count++;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CP_W-1:0] any_cp();
        return CP_TOP & $urandom;
    endfunction

    // Mostly real classes; error and the unused code seven now and then.
    function automatic logic [CLS_W-1:0] pick_class();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 8) return CLS_W'(r);
        return CLS_W'(1 + r % 6);
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [CP_W-1:0] cp,
                        input logic [IDX_W-1:0] idx, input logic [CP_W-1:0] first,
                        input logic [CP_W-1:0] last, input logic [CLS_W-1:0] cls);
        width_req_t r;
        r.op    = op;
        r.cp    = cp;
        r.idx   = idx;
        r.first = first;
        r.last  = last;
        r.cls   = cls;
        pending_reqs.push_back(r);
    endtask

    task automatic load_range(input int unsigned idx, input logic [CP_W-1:0] first,
                              input logic [CP_W-1:0] last, input logic [CLS_W-1:0] cls);
        send(OP_LOAD_RANGE, any_cp(), IDX_W'(idx), first, last, cls);
        aim_first[idx] = first;
        aim_last[idx]  = last;
    endtask

    task automatic load_ascii(input int unsigned idx, input logic [CLS_W-1:0] cls);
        send(OP_LOAD_ASCII, any_cp(), IDX_W'(idx), any_cp(), any_cp(), cls);
    endtask

    task automatic query(input logic [CP_W-1:0] cp);
        send(OP_QUERY, cp, IDX_W'($urandom), any_cp(), any_cp(), CLS_W'($urandom));
    endtask

    // Aim at the ends of a live entry, just outside them, inside, into the ASCII block, or anywhere.
    task automatic query_near(input int unsigned count);
        int unsigned live, k, pick;
        live = (count > RANGE_DEPTH) ? RANGE_DEPTH : count;
        pick = $urandom_range(0, 9);
        if (live == 0 || pick == 9) begin
            query(any_cp());
        end else if (pick == 8) begin
            query(CP_W'($urandom_range(0, ASCII_LIMIT - 1)));
        end else begin
            k = $urandom_range(0, live - 1);
            case (pick)
                0:       query(aim_first[k]);
                1:       query(aim_last[k]);
                2:       query(aim_first[k] - 1'b1);
                3:       query(aim_last[k] + 1'b1);
                default: query(CP_W'($urandom_range(aim_first[k], aim_last[k])));
            endcase
        end
    endtask

    // Sorted, disjoint ranges spread over the space above the ASCII block;
    // some touch their neighbour, some are single code points.
    task automatic fill_sorted(input int unsigned n);
        int unsigned slot, base, first, last;
        slot = (CP_TOP - ASCII_LIMIT + 1) / n;
        last = 0;
        for (int unsigned i = 0; i < n; i++) begin
            base = ASCII_LIMIT + i * slot;
            if (i > 0 && $urandom_range(0, 3) == 0) first = last + 1;
            else first = base + $urandom_range(0, slot / 4);
            if (i == 0 && $urandom_range(0, 3) == 0) first = ASCII_LIMIT;
            last = first + $urandom_range(0, slot / 2);
            if (i == n - 1 && $urandom_range(0, 3) == 0) last = CP_TOP;
            load_range(i, CP_W'(first), CP_W'(last), pick_class());
        end
    endtask

    // Unsorted, overlapping and reversed ranges.
    task automatic fill_noise(input int unsigned n);
        logic [CP_W-1:0] first;
        for (int unsigned i = 0; i < n; i++) begin
            first = any_cp();
            if ($urandom_range(0, 1)) load_range(i, first, any_cp(), pick_class());
            else load_range(i, first, first + CP_W'($urandom_range(0, 4095)), pick_class());
        end
    endtask

    // Hold off until the driver is empty and every answer is in, then let
    // the block settle; loads leave nothing behind to wait on.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || item_ch.valid || expected_widths.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_entries(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        entries_cfg = value;
        setting_count++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int unsigned n, count, len, pick;

    initial begin
        fail_count       = 0;
        query_count      = 0;
        high_query_count = 0;
        load_count       = 0;
        setting_count    = 0;
        random_items     = 0;
        entries_cfg      = 0;

        // every input known from time zero
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        item_ch.valid         = 1'b0;
        item_ch.operation     = OP_QUERY;
        item_ch.code_point    = '0;
        item_ch.entry_index   = '0;
        item_ch.range_first   = '0;
        item_ch.range_last    = '0;
        item_ch.entry_class   = CLS_ERROR;
        result_ch.ready       = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty range table: fill the ASCII block (every class shows up),
        // try a dropped ASCII slot and the unused operation, then query both
        // ends of the ASCII block and the empty search above it.
        for (int unsigned i = 0; i < ASCII_DEPTH; i++) load_ascii(i, CLS_W'(i));
        load_ascii($urandom_range(ASCII_DEPTH, 2047), CLS_N);
        send(OP_UNUSED, any_cp(), IDX_W'($urandom), any_cp(), any_cp(), CLS_W'($urandom));
        query('0);
        query(ASCII_LIMIT - 1'b1);
        query(ASCII_LIMIT);
        query(21'h10FFFF);
        query(21'h110000);
        query(CP_TOP);

        // Small sorted table with hand-placed extremes and a class seven entry.
        fill_sorted(16);
        load_range(0, ASCII_LIMIT, aim_last[0], CLS_W_CL);
        load_range(15, aim_first[15], CP_TOP, CLS_SEVEN);
        set_entries(12'd16);
        query(ASCII_LIMIT);
        query(CP_TOP);
        query(aim_first[15] - 1'b1);
        query(aim_last[7]);
        query(aim_last[7] + 1'b1);
        query(aim_first[8]);
        query(21'h10FFFF);
        query(ASCII_LIMIT - 1'b1);

        // Full table, then the count at its oversized extreme, one short, and empty.
        fill_sorted(RANGE_DEPTH);
        set_entries(CFG_W'(RANGE_DEPTH));
        for (int i = 0; i < 40; i++) query_near(RANGE_DEPTH);
        set_entries(CFG_TOP);
        for (int i = 0; i < 20; i++) query_near(RANGE_DEPTH);
        set_entries(CFG_W'(RANGE_DEPTH - 1));
        for (int i = 0; i < 20; i++) query_near(RANGE_DEPTH - 1);
        set_entries('0);
        for (int i = 0; i < 10; i++) query_near(0);

        // Random phases: reload a table (mostly small, mostly well formed),
        // pick a count, and query it with a few loads and junk mixed in.
        // Each phase waits until all answers are back before the count moves.
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) n = $urandom_range(1, 24);
            else if (pick < 9) n = $urandom_range(25, 200);
            else n = $urandom_range(201, 600);
            if ($urandom_range(0, 19) < 17) fill_sorted(n);
            else fill_noise(n);
            random_items += n;

            case ($urandom_range(0, 19))
                0:       count = $urandom_range(RANGE_DEPTH + 1, CFG_TOP);
                1:       count = $urandom_range(0, RANGE_DEPTH);
                2:       count = 0;
                default: count = n;
            endcase
            set_entries(CFG_W'(count));

            len = $urandom_range(15, 60);
            for (int unsigned i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    query_near(count);
                    random_items++;
                end else if (pick < 92) begin
                    load_range($urandom_range(0, RANGE_DEPTH - 1), any_cp(), any_cp(),
                               pick_class());
                    random_items++;
                end else if (pick < 97) begin
                    if ($urandom_range(0, 3) == 0) begin
                        load_ascii($urandom_range(ASCII_DEPTH, 2047), pick_class());
                    end else begin
                        load_ascii($urandom_range(0, ASCII_DEPTH - 1), pick_class());
                        random_items++;
                    end
                end else begin
                    send(OP_UNUSED, any_cp(), IDX_W'($urandom), any_cp(), any_cp(),
                         CLS_W'($urandom));
                end
            end
        end

        wait_idle();
        $display("Covered %0d queries (%0d searched above the ASCII block) and %0d loads",
                 query_count, high_query_count, load_count);
        $display("over %0d range-count settings, sorted and unsorted tables alike.",
                 setting_count);
        if (fail_count == 0) begin
            $display("east_asian_width_lookup test passed");
        end else begin
            $display("east_asian_width_lookup test failed");
        end
        $finish;
    end

endmodule
